[design/stack_machine_execute_macros.svh]
// assertion macros for the stack machine execute block
// used by the top level only, needs clk and rst_n in scope
`ifndef STACK_MACHINE_EXECUTE_MACROS_SVH
`define STACK_MACHINE_EXECUTE_MACROS_SVH

// same-cycle implication
`define SMX_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SMX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/smx_pkg.sv]
// shared types and constants of the stack machine execute block
// no dependencies
package smx_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [4:0] {
    OP_LDC  = 5'd0,  OP_LD  = 5'd1,  OP_ALD = 5'd2,  OP_ST  = 5'd3,
    OP_AST  = 5'd4,  OP_PUSH = 5'd5, OP_POP = 5'd6,  OP_JMP = 5'd7,
    OP_JZ   = 5'd8,  OP_ADD = 5'd9,  OP_SUB = 5'd10, OP_MUL = 5'd11,
    OP_DIV  = 5'd12, OP_LT  = 5'd13, OP_LE  = 5'd14, OP_GT  = 5'd15,
    OP_GE   = 5'd16, OP_EQ  = 5'd17, OP_NE  = 5'd18, OP_IN  = 5'd19,
    OP_OUT  = 5'd20, OP_ADDR = 5'd21, OP_CALL = 5'd22, OP_RET = 5'd23
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_BADOP = 3'd1,
    ST_DIV0  = 3'd2,
    ST_OVER  = 3'd3,
    ST_UNDER = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    BS_IDLE, BS_RD, BS_RD2, BS_EXEC, BS_DIVW, BS_CALL2
  } bstate_t;

  typedef struct packed {
    logic [4:0]               op;
    logic signed [DATA_W-1:0] imm;
    logic signed [DATA_W-1:0] in_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0]              next_ip;
    logic signed [DATA_W-1:0] acc;
    logic                     out_valid;
    logic signed [DATA_W-1:0] out_value;
    logic [2:0]               status;
  } out_item_t;

  // classified instruction handed from front to back
  typedef struct packed {
    logic [4:0]        op;
    logic [DATA_W-1:0] imm;
    logic [DATA_W-1:0] in_value;
    logic              bad;
    logic              is_arith;
    logic              is_idx;
    logic              use_bp;
  } insn_t;

endpackage

[design/smx_chan_if.sv]
// valid/ready channel carrying one payload per beat
// payload type is set by the instantiating level
interface smx_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

[design/smx_front.sv]
// front end: accepts instruction beats, classifies them, two-entry queue
// depends on smx_pkg and smx_chan_if
module smx_front import smx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  smx_chan_if.sink    in_ch,
  output insn_t       head,
  output logic        head_v,
  input  logic        deq
);

  insn_t      q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  insn_t      cls;
  logic       enq;

  always_comb begin
    cls.op       = in_ch.payload.op;
    cls.imm      = in_ch.payload.imm;
    cls.in_value = in_ch.payload.in_value;
    cls.bad      = in_ch.payload.op > OP_RET;
    cls.is_arith = in_ch.payload.op >= OP_ADD && in_ch.payload.op <= OP_NE;
    cls.is_idx   = in_ch.payload.op == OP_LD || in_ch.payload.op == OP_ALD ||
                   in_ch.payload.op == OP_ST || in_ch.payload.op == OP_AST;
    cls.use_bp   = in_ch.payload.op == OP_LD || in_ch.payload.op == OP_ST;
  end

  assign in_ch.ready = cnt_r != 2'd2;
  assign enq         = in_ch.valid && in_ch.ready;
  assign head        = q_r[rp_r];
  assign head_v      = cnt_r != 2'd0;

  always_comb begin
    wp_nxt  = enq ? ~wp_r : wp_r;
    rp_nxt  = deq ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(enq) - 2'(deq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

[design/smx_div.sv]
// iterative signed divider, one quotient bit per cycle, truncating
// depends on smx_pkg
module smx_div import smx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dvd,
  input  logic [DATA_W-1:0] dvs,
  output logic              done,
  output logic [DATA_W-1:0] quo
);

  localparam int SW = $clog2(DATA_W);

  logic              busy_r, busy_nxt, done_r, done_nxt, neg_r, neg_nxt;
  logic [SW-1:0]     step_r, step_nxt;
  logic [DATA_W-1:0] q_r, q_nxt, rem_r, rem_nxt, d_r, d_nxt;
  logic [DATA_W:0]   rem_s, diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    step_nxt = step_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    rem_s    = {rem_r, q_r[DATA_W-1]};
    diff     = rem_s - {1'b0, d_r};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      q_nxt    = dvd[DATA_W-1] ? -dvd : dvd;
      d_nxt    = dvs[DATA_W-1] ? -dvs : dvs;
      rem_nxt  = '0;
      neg_nxt  = dvd[DATA_W-1] ^ dvs[DATA_W-1];
    end else if (busy_r) begin
      if (!diff[DATA_W]) begin
        rem_nxt = diff[DATA_W-1:0];
        q_nxt   = {q_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_s[DATA_W-1:0];
        q_nxt   = {q_r[DATA_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == SW'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    step_r <= step_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    d_r    <= d_nxt;
  end

  assign done = done_r;
  assign quo  = neg_r ? -q_r : q_r;

endmodule

[design/smx_back.sv]
// back end: sequencer that executes one instruction, owns stack memory
// depends on smx_pkg, smx_chan_if and smx_div
module smx_back import smx_pkg::*; #(
  parameter int STACK_DEPTH       = 1024,
  parameter int PROGRAM_ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  insn_t       head,
  input  logic        head_v,
  output logic        deq,
  smx_chan_if.source  out_ch
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int PW = PROGRAM_ADDR_BITS;

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_r, wdata;
  logic [AW-1:0]     raddr, waddr;
  logic              we;

  bstate_t           state_r, state_nxt;
  insn_t             cur_r, cur_nxt, ins;
  logic [DATA_W-1:0] a_r, a_nxt, acc_r, acc_nxt, bp_r, bp_nxt;
  logic [PW-1:0]     ip_r, ip_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt, cnt_m1, cnt_m2, cnt_p1;
  logic              res_v_r, res_v_nxt;
  out_item_t         res_r, res_nxt;

  logic signed [DATA_W+1:0] idx;
  logic              idx_ok;
  logic [2*DATA_W-1:0] prod;
  logic              div_start, div_done;
  logic [DATA_W-1:0] div_q;

  // finishing values
  logic              fin;
  status_t           f_st;
  logic [DATA_W-1:0] f_acc, f_bp, f_nip;
  logic [CW-1:0]     f_cnt;
  logic              f_outv;

  smx_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (a_r),
    .dvs   (acc_r),
    .done  (div_done),
    .quo   (div_q)
  );

  assign ins    = (state_r == BS_IDLE) ? head : cur_r;
  assign cnt_m1 = cnt_r - CW'(1);
  assign cnt_m2 = cnt_r - CW'(2);
  assign cnt_p1 = cnt_r + CW'(1);
  assign prod   = a_r * acc_r;

  always_comb begin
    if (ins.use_bp) begin
      idx = {{2{bp_r[DATA_W-1]}}, bp_r} - {{2{acc_r[DATA_W-1]}}, acc_r};
    end else begin
      idx = {{2{acc_r[DATA_W-1]}}, acc_r};
    end
    idx_ok = !idx[DATA_W+1] && (idx < (DATA_W+2)'(cnt_r));
  end

  // read address: indexed word for loads, top of stack otherwise, second word afterwards
  always_comb begin
    if (state_r == BS_IDLE) begin
      raddr = (ins.is_idx && (ins.op == OP_LD || ins.op == OP_ALD)) ?
              idx[AW-1:0] : cnt_m1[AW-1:0];
    end else begin
      raddr = cnt_m2[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    a_nxt     = a_r;
    acc_nxt   = acc_r;
    bp_nxt    = bp_r;
    ip_nxt    = ip_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    res_v_nxt = res_v_r && !out_ch.ready;
    deq       = 1'b0;
    we        = 1'b0;
    waddr     = cnt_r[AW-1:0];
    wdata     = acc_r;
    div_start = 1'b0;
    fin       = 1'b0;
    f_st      = ST_OK;
    f_acc     = acc_r;
    f_bp      = bp_r;
    f_cnt     = cnt_r;
    f_nip     = DATA_W'(ip_r) + 1'b1;
    f_outv    = 1'b0;

    unique case (state_r)
      BS_IDLE: begin
        if (head_v && (!res_v_r || out_ch.ready)) begin
          deq       = 1'b1;
          cur_nxt   = head;
          state_nxt = BS_RD;
        end
      end
      BS_RD: begin
        a_nxt     = rd_r;
        state_nxt = (cur_r.op == OP_RET) ? BS_RD2 : BS_EXEC;
      end
      BS_RD2: begin
        state_nxt = BS_EXEC;
      end
      BS_EXEC: begin
        if (cur_r.bad) begin
          f_st = ST_BADOP;
        end else if (cur_r.is_arith && cnt_r == '0) begin
          f_st = ST_UNDER;
        end else begin
          case (cur_r.op)
            OP_LD, OP_ALD:  if (!idx_ok) f_st = ST_UNDER;
            OP_ST, OP_AST:  if (cnt_r == '0 || !idx_ok) f_st = ST_UNDER;
            OP_PUSH:        if (cnt_r >= CW'(STACK_DEPTH)) f_st = ST_OVER;
            OP_POP:         if (cnt_r == '0) f_st = ST_UNDER;
            OP_DIV:         if (acc_r == '0) f_st = ST_DIV0;
            OP_CALL:        if (cnt_r > CW'(STACK_DEPTH - 2)) f_st = ST_OVER;
            OP_RET:         if (cnt_r < CW'(2)) f_st = ST_UNDER;
            default: ;
          endcase
        end
        fin = 1'b1;
        if (f_st == ST_OK) begin
          case (cur_r.op)
            OP_LDC:  f_acc = cur_r.imm;
            OP_LD, OP_ALD: f_acc = a_r;
            OP_ST, OP_AST: begin
              we    = 1'b1;
              waddr = idx[AW-1:0];
              wdata = a_r;
            end
            OP_PUSH: begin
              we    = 1'b1;
              f_cnt = cnt_p1;
            end
            OP_POP:  f_cnt = cnt_m1;
            OP_JMP:  f_nip = DATA_W'(ip_r) + cur_r.imm;
            OP_JZ:   if (acc_r == '0) f_nip = DATA_W'(ip_r) + cur_r.imm;
            OP_ADD:  f_acc = a_r + acc_r;
            OP_SUB:  f_acc = a_r - acc_r;
            OP_MUL:  f_acc = prod[DATA_W-1:0];
            OP_DIV: begin
              fin       = 1'b0;
              div_start = 1'b1;
              state_nxt = BS_DIVW;
            end
            OP_LT:   f_acc = DATA_W'($signed(a_r) <  $signed(acc_r));
            OP_LE:   f_acc = DATA_W'($signed(a_r) <= $signed(acc_r));
            OP_GT:   f_acc = DATA_W'($signed(a_r) >  $signed(acc_r));
            OP_GE:   f_acc = DATA_W'($signed(a_r) >= $signed(acc_r));
            OP_EQ:   f_acc = DATA_W'(a_r == acc_r);
            OP_NE:   f_acc = DATA_W'(a_r != acc_r);
            OP_IN:   f_acc = cur_r.in_value;
            OP_OUT:  f_outv = 1'b1;
            OP_ADDR: f_acc = DATA_W'(cnt_r) - cur_r.imm;
            OP_CALL: begin
              // first push: old base pointer
              fin       = 1'b0;
              we        = 1'b1;
              wdata     = bp_r;
              state_nxt = BS_CALL2;
            end
            OP_RET: begin
              f_nip = a_r + 1'b1;
              f_bp  = rd_r;
              f_cnt = cnt_m2;
            end
            default: ;
          endcase
        end
      end
      BS_DIVW: begin
        if (div_done) begin
          fin   = 1'b1;
          f_acc = div_q;
        end
      end
      BS_CALL2: begin
        // second push: return address
        we    = 1'b1;
        waddr = cnt_p1[AW-1:0];
        wdata = DATA_W'(ip_r);
        fin   = 1'b1;
        f_cnt = cnt_r + CW'(2);
        f_bp  = DATA_W'(cnt_r) - 1'b1;
        f_nip = DATA_W'(ip_r) + cur_r.imm;
      end
      default: state_nxt = BS_IDLE;
    endcase

    if (fin) begin
      state_nxt = BS_IDLE;
      res_v_nxt = 1'b1;
      res_nxt.status = f_st;
      if (f_st == ST_OK) begin
        acc_nxt = f_acc;
        bp_nxt  = f_bp;
        cnt_nxt = f_cnt;
        ip_nxt  = PW'(f_nip);
        res_nxt.next_ip   = 16'(PW'(f_nip));
        res_nxt.acc       = f_acc;
        res_nxt.out_valid = f_outv;
        res_nxt.out_value = f_outv ? acc_r : '0;
      end else begin
        res_nxt.next_ip   = 16'(ip_r);
        res_nxt.acc       = acc_r;
        res_nxt.out_valid = 1'b0;
        res_nxt.out_value = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
      acc_r   <= '0;
      bp_r    <= '0;
      ip_r    <= '0;
      cnt_r   <= '0;
      res_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      bp_r    <= bp_nxt;
      ip_r    <= ip_nxt;
      cnt_r   <= cnt_nxt;
      res_v_r <= res_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    a_r   <= a_nxt;
    res_r <= res_nxt;
  end

  assign out_ch.valid   = res_v_r;
  assign out_ch.payload = res_r;

endmodule

[design/stack_machine_execute.sv]
// stack machine execute, top level: front queue, back sequencer, result register.
// Depends on smx_pkg, smx_chan_if, smx_front, smx_back and the macros header.
// Each input beat is one instruction of an accumulator-plus-stack machine; the block
// keeps the accumulator, base pointer, instruction pointer and a stack memory of
// STACK_DEPTH words, and returns one result beat per instruction with the next ip,
// the accumulator, any OUT value and a status. The front end takes beats into a
// two-entry queue, so up to two instructions can wait while the back end works.
// The back end handles one instruction at a time. Most opcodes step through issue
// stack read, capture operand and execute; RET adds a step for the second stack
// word, CALL a second push step, and DIV waits on the divider, whose quotient comes
// one bit per cycle. The stack memory has one read and one write port with
// registered read data. A faulting instruction leaves all state alone and reports
// the current ip and accumulator. Stack words never written read as whatever the
// memory holds; the machine never uses a word read from above the stack count.
`include "stack_machine_execute_macros.svh"

module stack_machine_execute import smx_pkg::*; #(
  parameter int STACK_DEPTH       = 1024,
  parameter int PROGRAM_ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  smx_chan_if.sink    in_ch,
  smx_chan_if.source  out_ch
);

  // queue head between front and back
  insn_t head;
  logic  head_v;
  logic  deq;

  smx_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .head   (head),
    .head_v (head_v),
    .deq    (deq)
  );

  // back end also holds the output register
  smx_back #(
    .STACK_DEPTH       (STACK_DEPTH),
    .PROGRAM_ADDR_BITS (PROGRAM_ADDR_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .head_v (head_v),
    .deq    (deq),
    .out_ch (out_ch)
  );

  // back end only pops a queue entry that exists
  `SMX_ASSERT_IMPL(a_deq_valid, deq, head_v, "pop from empty queue")

  // each instruction keeps the back end busy past its own pop, so pops never come back to back
  `SMX_ASSERT_NEXT(a_deq_spacing, deq, !deq, "back-to-back pops")

  // an emitted value is the accumulator and only comes on a clean result
  `SMX_ASSERT_IMPL(a_out_value,
    out_ch.valid && out_ch.payload.out_valid,
    out_ch.payload.out_value == out_ch.payload.acc &&
    out_ch.payload.status == ST_OK,
    "out value mismatch")

endmodule
